// ----- src/rguf_pkg.sv -----
`default_nettype none
// ============================================================================
// rguf_pkg
// Shared types and constants for the range-gated union-find block.
// ============================================================================
package rguf_pkg;

    localparam int IDX_W         = 10;
    localparam int POS_W         = 16;
    localparam int RANGE_W       = 15;
    localparam int RANK_W        = 4;
    localparam int SQ_W          = 32;
    localparam int SUM_W         = 34;
    localparam int R2_W          = 2 * RANGE_W;
    localparam int PARTICLES_DEF = 1024;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = 2;
    localparam int Q_CNT_W       = 3;
    localparam int FLIGHT_W      = 2;
    localparam int OCC_W         = 4;

    localparam logic [RANGE_W-1:0] RANGE_RESET = 15'd512;
    localparam logic [RANK_W-1:0]  RANK_MAX    = 4'd15;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LINK  = 2'd1,
        OP_FIND  = 2'd2,
        OP_NONE  = 2'd3
    } rguf_op_t;

    // One classified word passed from front to back
    typedef struct packed {
        rguf_op_t         operation;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] second_index;
        logic             near;
    } rguf_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FSTART,
        ST_FREAD,
        ST_FCHECK,
        ST_CCHECK,
        ST_CWRITE,
        ST_FDONE,
        ST_RREADA,
        ST_RREADB,
        ST_UNITE
    } rguf_state_t;

    // Which find the walker is running
    typedef enum logic [1:0] {
        PH_FIND,
        PH_FA1,
        PH_FB,
        PH_FA2
    } rguf_phase_t;

endpackage
`default_nettype wire

// ----- src/rguf_front.sv -----
`default_nettype none
// ============================================================================
// rguf_front
// Accepts words and classifies links by the squared-distance range test.
// ============================================================================
module rguf_front (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   accept,
    input  wire logic [1:0]                             operation,
    input  wire logic [rguf_pkg::IDX_W-1:0]             first_index,
    input  wire logic [rguf_pkg::IDX_W-1:0]             second_index,
    input  wire logic signed [rguf_pkg::POS_W-1:0]      first_x,
    input  wire logic signed [rguf_pkg::POS_W-1:0]      first_y,
    input  wire logic signed [rguf_pkg::POS_W-1:0]      first_z,
    input  wire logic signed [rguf_pkg::POS_W-1:0]      second_x,
    input  wire logic signed [rguf_pkg::POS_W-1:0]      second_y,
    input  wire logic signed [rguf_pkg::POS_W-1:0]      second_z,
    input  wire logic [rguf_pkg::RANGE_W-1:0]           cohesion_range,
    output rguf_pkg::rguf_item_t                        item,
    output logic                                        item_valid,
    output logic [rguf_pkg::FLIGHT_W-1:0]               inflight
);
    import rguf_pkg::*;

    logic                v1_reg, v2_reg, v3_reg;
    rguf_item_t          item1_reg, item2_reg, item3_reg;
    logic [POS_W:0]      dx_reg, dy_reg, dz_reg;
    logic [POS_W:0]      ax, ay, az;
    logic [SQ_W-1:0]     sqx_reg, sqy_reg, sqz_reg;
    logic [R2_W-1:0]     r2_reg;
    logic [SUM_W-1:0]    sum;
    rguf_item_t          item1_next;
    rguf_item_t          item3_next;

    // Track the squared range
    always_ff @(posedge clk)
    begin
        r2_reg <= R2_W'(cohesion_range) * R2_W'(cohesion_range);
    end

    // Valid bits of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        item1_next.operation    = rguf_op_t'(operation);
        item1_next.first_index  = first_index;
        item1_next.second_index = second_index;
        item1_next.near         = 1'b0;
    end

    // Stage one: coordinate differences
    always_ff @(posedge clk)
    begin
        item1_reg <= item1_next;
        dx_reg    <= {first_x[POS_W-1], first_x} - {second_x[POS_W-1], second_x};
        dy_reg    <= {first_y[POS_W-1], first_y} - {second_y[POS_W-1], second_y};
        dz_reg    <= {first_z[POS_W-1], first_z} - {second_z[POS_W-1], second_z};
    end

    // Stage two: magnitudes and squares
    assign ax = dx_reg[POS_W] ? (~dx_reg + (POS_W+1)'(1)) : dx_reg;
    assign ay = dy_reg[POS_W] ? (~dy_reg + (POS_W+1)'(1)) : dy_reg;
    assign az = dz_reg[POS_W] ? (~dz_reg + (POS_W+1)'(1)) : dz_reg;

    always_ff @(posedge clk)
    begin
        item2_reg <= item1_reg;
        sqx_reg   <= SQ_W'(ax[POS_W-1:0]) * SQ_W'(ax[POS_W-1:0]);
        sqy_reg   <= SQ_W'(ay[POS_W-1:0]) * SQ_W'(ay[POS_W-1:0]);
        sqz_reg   <= SQ_W'(az[POS_W-1:0]) * SQ_W'(az[POS_W-1:0]);
    end

    // Stage three: sum and compare against the range
    assign sum = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);

    always_comb
    begin
        item3_next      = item2_reg;
        item3_next.near = (sum < SUM_W'(r2_reg));
    end

    always_ff @(posedge clk)
    begin
        item3_reg <= item3_next;
    end

    assign item       = item3_reg;
    assign item_valid = v3_reg;
    assign inflight   = FLIGHT_W'(v1_reg) + FLIGHT_W'(v2_reg) + FLIGHT_W'(v3_reg);

endmodule
`default_nettype wire

// ----- src/rguf_queue.sv -----
`default_nettype none
// ============================================================================
// rguf_queue
// Short FIFO of classified words between front and back.
// ============================================================================
module rguf_queue (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    input  wire rguf_pkg::rguf_item_t            push_item,
    input  wire logic                            pop,
    output rguf_pkg::rguf_item_t                 head,
    output logic                                 head_valid,
    output logic [rguf_pkg::Q_CNT_W-1:0]         count
);
    import rguf_pkg::*;

    rguf_item_t           slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

endmodule
`default_nettype wire

// ----- src/rguf_back.sv -----
`default_nettype none
// ============================================================================
// rguf_back
// Walks and updates the parent and rank memories for clear, link and find.
// ============================================================================
module rguf_back #(
    parameter int PARTICLES = rguf_pkg::PARTICLES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rguf_pkg::rguf_item_t          head,
    input  wire logic                          head_valid,
    output logic                               pop,
    output logic                               init_busy,
    output logic                               done,
    output logic [rguf_pkg::IDX_W-1:0]         root,
    output logic                               in_range,
    output logic                               merged
);
    import rguf_pkg::*;

    localparam int AW = $clog2(PARTICLES);

    logic [IDX_W-1:0]  parent_mem [PARTICLES];
    logic [RANK_W-1:0] rank_mem   [PARTICLES];
    logic [IDX_W-1:0]  parent_q;
    logic [RANK_W-1:0] rank_q;

    logic [AW-1:0]     p_raddr, p_waddr, rk_raddr, rk_waddr;
    logic [IDX_W-1:0]  p_wdata;
    logic [RANK_W-1:0] rk_wdata;
    logic              p_we, rk_we;

    rguf_state_t       state_reg, state_next;
    rguf_phase_t       phase_reg, phase_next;
    logic [IDX_W-1:0]  cur_reg, cur_next, r_reg, r_next;
    logic [IDX_W-1:0]  ra_reg, ra_next, rb_reg, rb_next;
    logic [IDX_W-1:0]  a_reg, a_next, b_reg, b_next;
    logic              near_reg, near_next, joined_reg, joined_next;
    logic [RANK_W-1:0] rank_a_reg, rank_a_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic              clr_op_reg, clr_op_next;
    logic              done_reg, done_next;
    logic [IDX_W-1:0]  root_reg, root_next;
    logic              in_range_reg, in_range_next, merged_reg, merged_next;

    function automatic logic stored(input logic [IDX_W-1:0] e);
        stored = (32'(e) < 32'(PARTICLES));
    endfunction

    // Parent memory
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            parent_mem[p_waddr] <= p_wdata;
        end
        parent_q <= parent_mem[p_raddr];
    end

    // Rank memory
    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rank_mem[rk_waddr] <= rk_wdata;
        end
        rank_q <= rank_mem[rk_raddr];
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            phase_reg  <= PH_FIND;
            cnt_reg    <= '0;
            clr_op_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            clr_op_reg <= clr_op_next;
            done_reg   <= done_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        r_reg        <= r_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        near_reg     <= near_next;
        joined_reg   <= joined_next;
        rank_a_reg   <= rank_a_next;
        root_reg     <= root_next;
        in_range_reg <= in_range_next;
        merged_reg   <= merged_next;
    end

    // Sequence clear, find walk, compression and union
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cur_next      = cur_reg;
        r_next        = r_reg;
        ra_next       = ra_reg;
        rb_next       = rb_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        near_next     = near_reg;
        joined_next   = joined_reg;
        rank_a_next   = rank_a_reg;
        cnt_next      = cnt_reg;
        clr_op_next   = clr_op_reg;
        done_next     = 1'b0;
        root_next     = root_reg;
        in_range_next = in_range_reg;
        merged_next   = merged_reg;
        pop           = 1'b0;
        p_raddr       = AW'(r_reg);
        p_waddr       = AW'(cur_reg);
        p_wdata       = r_reg;
        p_we          = 1'b0;
        rk_raddr      = AW'(ra_reg);
        rk_waddr      = AW'(ra_reg);
        rk_wdata      = rank_a_reg + RANK_W'(1);
        rk_we         = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                p_we     = 1'b1;
                p_waddr  = cnt_reg;
                p_wdata  = IDX_W'(cnt_reg);
                rk_we    = 1'b1;
                rk_waddr = cnt_reg;
                rk_wdata = '0;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(PARTICLES - 1))
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                    if (clr_op_reg)
                    begin
                        done_next     = 1'b1;
                        root_next     = '0;
                        in_range_next = 1'b0;
                        merged_next   = 1'b0;
                    end
                end
            end

            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop         = 1'b1;
                    a_next      = head.first_index;
                    b_next      = head.second_index;
                    cur_next    = head.first_index;
                    joined_next = 1'b0;
                    near_next   = 1'b0;
                    phase_next  = PH_FIND;
                    unique case (head.operation)
                        OP_CLEAR:
                        begin
                            cnt_next    = '0;
                            clr_op_next = 1'b1;
                            state_next  = ST_CLEAR;
                        end
                        OP_LINK:
                        begin
                            near_next  = head.near;
                            state_next = ST_FSTART;
                            if (head.near && stored(head.first_index)
                                && stored(head.second_index))
                            begin
                                phase_next = PH_FA1;
                            end
                        end
                        OP_FIND:
                        begin
                            state_next = ST_FSTART;
                        end
                        default:
                        begin
                            done_next     = 1'b1;
                            root_next     = '0;
                            in_range_next = 1'b0;
                            merged_next   = 1'b0;
                        end
                    endcase
                end
            end

            ST_FSTART:
            begin
                r_next     = cur_reg;
                state_next = stored(cur_reg) ? ST_FREAD : ST_FDONE;
            end

            ST_FREAD:
            begin
                p_raddr    = AW'(r_reg);
                state_next = ST_FCHECK;
            end

            ST_FCHECK:
            begin
                if (parent_q == r_reg)
                begin
                    state_next = ST_CCHECK;
                end
                else
                begin
                    r_next     = parent_q;
                    state_next = ST_FREAD;
                end
            end

            ST_CCHECK:
            begin
                p_raddr = AW'(cur_reg);
                if (cur_reg == r_reg)
                begin
                    state_next = ST_FDONE;
                end
                else
                begin
                    state_next = ST_CWRITE;
                end
            end

            ST_CWRITE:
            begin
                p_we       = 1'b1;
                p_waddr    = AW'(cur_reg);
                p_wdata    = r_reg;
                cur_next   = parent_q;
                state_next = ST_CCHECK;
            end

            ST_FDONE:
            begin
                unique case (phase_reg)
                    PH_FA1:
                    begin
                        ra_next    = r_reg;
                        cur_next   = b_reg;
                        phase_next = PH_FB;
                        state_next = ST_FSTART;
                    end
                    PH_FB:
                    begin
                        rb_next = r_reg;
                        if (ra_reg != r_reg)
                        begin
                            state_next = ST_RREADA;
                        end
                        else
                        begin
                            cur_next   = a_reg;
                            phase_next = PH_FA2;
                            state_next = ST_FSTART;
                        end
                    end
                    default:
                    begin
                        done_next     = 1'b1;
                        root_next     = r_reg;
                        in_range_next = near_reg;
                        merged_next   = joined_reg;
                        state_next    = ST_IDLE;
                    end
                endcase
            end

            ST_RREADA:
            begin
                rk_raddr   = AW'(ra_reg);
                state_next = ST_RREADB;
            end

            ST_RREADB:
            begin
                rk_raddr    = AW'(rb_reg);
                rank_a_next = rank_q;
                state_next  = ST_UNITE;
            end

            ST_UNITE:
            begin
                joined_next = 1'b1;
                p_we        = 1'b1;
                if (rank_a_reg < rank_q)
                begin
                    p_waddr = AW'(ra_reg);
                    p_wdata = rb_reg;
                end
                else
                begin
                    p_waddr = AW'(rb_reg);
                    p_wdata = ra_reg;
                    if ((rank_a_reg == rank_q) && (rank_a_reg != RANK_MAX))
                    begin
                        rk_we    = 1'b1;
                        rk_waddr = AW'(ra_reg);
                        rk_wdata = rank_a_reg + RANK_W'(1);
                    end
                end
                cur_next   = a_reg;
                phase_next = PH_FA2;
                state_next = ST_FSTART;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign init_busy = (state_reg == ST_CLEAR) && !clr_op_reg;
    assign done      = done_reg;
    assign root      = root_reg;
    assign in_range  = in_range_reg;
    assign merged    = merged_reg;

    // A merge is only reported for a pair found within range
    a_merge_near: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && merged_reg) |-> in_range_reg)
        else $error("merge reported without range hit");

    // Union only ever joins two distinct roots
    a_unite_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UNITE) |-> (ra_reg != rb_reg))
        else $error("union of a root with itself");

    // Rank writes come only from the clear sweep or a union
    a_rank_write: assert property (@(posedge clk) disable iff (!rst_n)
        rk_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_UNITE)))
        else $error("stray rank write");

    // Compression never redirects the root itself
    a_compress: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CWRITE) |-> (cur_reg != r_reg))
        else $error("root overwritten during compression");

endmodule
`default_nettype wire

// ----- src/range_gated_union_find.sv -----
`default_nettype none
// ============================================================================
// range_gated_union_find
// Disjoint-set forest with path compression, union by rank and a range gate.
// ============================================================================
// A word is taken when start is high and busy is low; each word yields one
// result, shown for one cycle with done high, which the receiver must take.
// Words pass a range classifier (differences, squares, sum and compare) and
// a four-word queue, then a sequencer on parent and rank memories that each
// have one read and one write port. A find walks up the parent chain and then
// compresses the path; a link in range with both indices stored finds the
// first index, the second and the first again, with a union between when the
// roots differ; clear sweeps both memories. After reset the memories are
// swept, and busy is high during the sweep.
module range_gated_union_find #(
    parameter int PARTICLES = rguf_pkg::PARTICLES_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic [1:0]                             operation,
    input  wire logic [rguf_pkg::IDX_W-1:0]             first_index,
    input  wire logic [rguf_pkg::IDX_W-1:0]             second_index,
    input  wire logic signed [rguf_pkg::POS_W-1:0]      first_x,
    input  wire logic signed [rguf_pkg::POS_W-1:0]      first_y,
    input  wire logic signed [rguf_pkg::POS_W-1:0]      first_z,
    input  wire logic signed [rguf_pkg::POS_W-1:0]      second_x,
    input  wire logic signed [rguf_pkg::POS_W-1:0]      second_y,
    input  wire logic signed [rguf_pkg::POS_W-1:0]      second_z,
    input  wire logic                                   cfg_we,
    input  wire logic [rguf_pkg::RANGE_W-1:0]           cfg_wdata,
    output logic                                        done,
    output logic [rguf_pkg::IDX_W-1:0]                  root,
    output logic                                        in_range,
    output logic                                        merged
);
    import rguf_pkg::*;

    logic [RANGE_W-1:0]  cohesion_range_reg;
    rguf_item_t          front_item, head;
    logic                front_valid, head_valid, pop, init_busy;
    logic [FLIGHT_W-1:0] inflight;
    logic [Q_CNT_W-1:0]  q_count;
    logic [OCC_W-1:0]    occupancy;
    logic                accept;

    // Hold the range register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cohesion_range_reg <= RANGE_RESET;
        end
        else if (cfg_we)
        begin
            cohesion_range_reg <= cfg_wdata;
        end
    end

    // Reserve a queue slot for every word still in the classifier
    assign occupancy = OCC_W'(q_count) + OCC_W'(inflight);
    assign busy      = init_busy || (occupancy >= OCC_W'(Q_DEPTH));
    assign accept    = start && !busy;

    rguf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .operation      (operation),
        .first_index    (first_index),
        .second_index   (second_index),
        .first_x        (first_x),
        .first_y        (first_y),
        .first_z        (first_z),
        .second_x       (second_x),
        .second_y       (second_y),
        .second_z       (second_z),
        .cohesion_range (cohesion_range_reg),
        .item           (front_item),
        .item_valid     (front_valid),
        .inflight       (inflight)
    );

    rguf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_item  (front_item),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .count      (q_count)
    );

    rguf_back #(
        .PARTICLES (PARTICLES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .init_busy  (init_busy),
        .done       (done),
        .root       (root),
        .in_range   (in_range),
        .merged     (merged)
    );

endmodule
`default_nettype wire
